[rtl/core/octree_cell_locator_macros.svh]
// Assertion macros for the octree cell locator checker.
`ifndef OCTREE_CELL_LOCATOR_MACROS_SVH
`define OCTREE_CELL_LOCATOR_MACROS_SVH

// Plain property held at every clock edge outside reset.
`define OCL_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define OCL_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OCL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ocl_pkg.sv]
// Types, widths and helpers shared by the octree cell locator.
`default_nettype none

package ocl_pkg;

    localparam int DEPTH_CAP  = 8;
    localparam int COORD_BITS = 32;
    localparam int CW         = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int FB         = 16 + DEPTH_CAP;      // internal fraction bits
    localparam int RSH        = 30 - FB;             // radius product shift
    localparam int TGT_W      = 32 + DEPTH_CAP;
    localparam int NODE_W     = TGT_W + 1;
    localparam int HW_W       = 31 + DEPTH_CAP;
    localparam int PROD_W     = 47;
    localparam int SUM_W      = 48;
    localparam int RAD_W      = SUM_W - RSH;
    localparam int CMP_W      = RAD_W + 3;
    localparam int LVL_W      = 4;
    localparam int PATH_W     = 3 * DEPTH_CAP;
    localparam int NUM_CELLS  = DEPTH_CAP + 1;
    localparam int IN_W       = 432;
    localparam int OUT_W      = 32;

    typedef enum logic [2:0] {
        REG_ROOT_CX   = 3'd0,
        REG_ROOT_CY   = 3'd1,
        REG_ROOT_CZ   = 3'd2,
        REG_ROOT_HALF = 3'd3,
        REG_LOOSE     = 3'd4,
        REG_DEPTH     = 3'd5
    } cfg_reg_e;

    typedef logic signed [TGT_W-1:0]  tgt_t;
    typedef logic signed [NODE_W-1:0] node_t;
    typedef logic [RAD_W-1:0]         rad_t;

    typedef struct packed {
        logic [2:0][31:0] box_center;
        logic [2:0][31:0] pos;
        logic [2:0][30:0] half_size;
        logic [2:0][47:0] axis;
    } item_t;

    typedef struct packed {
        logic [2:0][31:0] center;
        logic [30:0]      half;
        logic             loose;
    } front_cfg_t;

    typedef struct packed {
        logic             loose;
        logic [LVL_W-1:0] depth;
    } cell_ctl_t;

    typedef struct packed {
        tgt_t  [2:0]       tgt;
        node_t [2:0]       node;
        rad_t  [2:0]       rad;
        logic [HW_W-1:0]   hw;
        logic [LVL_W-1:0]  level;
        logic [PATH_W-1:0] path;
        logic              done;
        logic              cause;
    } cell_data_t;

    // Sign-extend a 32-bit field, wrapped to CW bits.
    function automatic logic signed [31:0] wrap_coord(input logic [31:0] v);
        logic [31:0] t;
        t = v << (32 - CW);
        return $signed(t) >>> (32 - CW);
    endfunction

endpackage

`default_nettype wire

[rtl/core/ocl_front.sv]
// Front stages: target select, radius products and sums, root node seed.
`default_nettype none

module ocl_front
    import ocl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire front_cfg_t cfg,
    input  wire logic       in_valid,
    input  wire item_t      item,
    output logic            out_valid,
    output cell_data_t      dout
);

    logic              va_reg, vb_reg, vc_reg;
    tgt_t [2:0]        tgt_a_reg, tgt_b_reg;
    logic [15:0]       absc_reg [3][3];   // [axis][box vector]
    logic [30:0]       hs_reg   [3];
    logic [PROD_W-1:0] prod_reg [3][3];
    cell_data_t        dc_reg;

    tgt_t [2:0]        tgt_sel;
    logic [15:0]       absc [3][3];
    logic [SUM_W-1:0]  sum  [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            tgt_sel[a] = $signed({wrap_coord(cfg.loose ? item.pos[a] : item.box_center[a]),
                                  {(FB-16){1'b0}}});
            for (int k = 0; k < 3; k++) begin
                absc[a][k] = item.axis[k][16*a+15] ? 16'(-item.axis[k][16*a +: 16])
                                                   : item.axis[k][16*a +: 16];
            end
            sum[a] = SUM_W'(prod_reg[a][0]) + SUM_W'(prod_reg[a][1])
                   + SUM_W'(prod_reg[a][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tgt_a_reg <= tgt_sel;
            tgt_b_reg <= tgt_a_reg;
            for (int a = 0; a < 3; a++) begin
                hs_reg[a] <= item.half_size[a];
                for (int k = 0; k < 3; k++) begin
                    absc_reg[a][k] <= absc[a][k];
                    prod_reg[a][k] <= PROD_W'(absc_reg[a][k]) * PROD_W'(hs_reg[k]);
                end
                dc_reg.tgt[a]  <= tgt_b_reg[a];
                dc_reg.node[a] <= NODE_W'($signed({wrap_coord(cfg.center[a]),
                                                   {(FB-16){1'b0}}}));
                dc_reg.rad[a]  <= sum[a][SUM_W-1:RSH];
            end
            dc_reg.hw    <= {cfg.half, {(HW_W-31){1'b0}}};
            dc_reg.level <= '0;
            dc_reg.path  <= '0;
            dc_reg.done  <= 1'b0;
            dc_reg.cause <= 1'b0;
        end
    end

    assign out_valid = vc_reg;
    assign dout      = dc_reg;

endmodule

`default_nettype wire

[rtl/core/ocl_cell.sv]
// One level cell: straddle or fit test, octant pick, child node step.
`default_nettype none

module ocl_cell
    import ocl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire cell_ctl_t  ctl,
    input  wire logic       in_valid,
    input  wire cell_data_t din,
    output logic            out_valid,
    output cell_data_t      dout
);

    logic                     valid_reg;
    cell_data_t               data_reg;
    cell_data_t               data_next;

    logic signed [CMP_W-1:0]  d     [3];
    logic signed [CMP_W-1:0]  absd  [3];
    logic signed [CMP_W-1:0]  rad_s [3];
    logic signed [CMP_W-1:0]  bound [3];
    logic [2:0]               fail;
    logic [2:0]               oct;
    logic [HW_W-1:0]          hw_half;
    logic signed [NODE_W-1:0] step;
    logic [PATH_W-1:0]        oct_ext;

    always_comb begin
        hw_half = din.hw >> 1;
        step    = $signed({{(NODE_W-HW_W){1'b0}}, hw_half});
        for (int a = 0; a < 3; a++) begin
            d[a]     = CMP_W'($signed(din.tgt[a])) - CMP_W'($signed(din.node[a]));
            absd[a]  = d[a][CMP_W-1] ? -d[a] : d[a];
            rad_s[a] = $signed({{(CMP_W-RAD_W){1'b0}}, din.rad[a]});
            // loose bound is twice the node half width less the radius
            bound[a] = $signed({{(CMP_W-HW_W-1){1'b0}}, din.hw, 1'b0}) - rad_s[a];
            fail[a]  = ctl.loose ? (absd[a] > bound[a]) : (absd[a] < rad_s[a]);
            oct[a]   = !d[a][CMP_W-1] && (d[a] != '0);
        end
        oct_ext   = PATH_W'(oct);
        data_next = din;
        if (!din.done) begin
            if (|fail) begin
                data_next.done  = 1'b1;
                data_next.cause = 1'b1;
            end else if (din.level >= ctl.depth) begin
                data_next.done  = 1'b1;
                data_next.cause = 1'b0;
            end else begin
                data_next.path  = din.path | (oct_ext << (6'(din.level) * 6'd3));
                data_next.hw    = hw_half;
                data_next.level = din.level + LVL_W'(1);
                for (int a = 0; a < 3; a++) begin
                    data_next.node[a] = oct[a] ? $signed(din.node[a]) + step
                                               : $signed(din.node[a]) - step;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign dout      = data_reg;

endmodule

`default_nettype wire

[rtl/core/octree_cell_locator.sv]
// Top level of the octree cell locator: config registers, front stages, level cells.
//
//  channel   dir  ports                     content
//  request   in   s_tvalid/s_tready/s_tdata  box, position, half sizes, axes
//  result    out  m_tvalid/m_tready/m_tdata  node level, octant path, stop cause
//  config    in   cfg_we/cfg_index/cfg_wdata register writes, no read-back
//
// A request passes three front stages for the radius products and sums, then
// one cell per tree level from the root to the leaves.
// A new request can enter every cycle while no result stalls; the cell row is a
// lock-step pipeline. A stalled result freezes the whole row, so s_tready is low
// while a result waits with m_tready low.
// Reset (aresetn low, synchronous) empties the row and restores the registers.
`default_nettype none

module octree_cell_locator
    import ocl_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // box_center_x/y/z, pos_x/y/z, half_size_x/y/z, axis_first/second/third
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // node_level, node_path, stop_cause
    output logic [OUT_W-1:0]      m_tdata,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [31:0]      cfg_wdata
);

    logic [2:0][31:0] center_reg;
    logic [30:0]      half_reg;
    logic             loose_reg;
    logic [3:0]       depth_reg;

    logic             en;
    item_t            item;
    front_cfg_t       fcfg;
    cell_ctl_t        ctl;

    logic             valid [NUM_CELLS+1];
    cell_data_t       data  [NUM_CELLS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= '0;
            half_reg   <= 31'd65536;
            loose_reg  <= 1'b0;
            depth_reg  <= 4'd4;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ROOT_CX:   center_reg[0] <= cfg_wdata;
                REG_ROOT_CY:   center_reg[1] <= cfg_wdata;
                REG_ROOT_CZ:   center_reg[2] <= cfg_wdata;
                REG_ROOT_HALF: half_reg      <= cfg_wdata[30:0];
                REG_LOOSE:     loose_reg     <= cfg_wdata[0];
                REG_DEPTH:     depth_reg     <= cfg_wdata[3:0];
                default:       ;
            endcase
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb begin
        item.box_center[0] = s_tdata[31:0];
        item.box_center[1] = s_tdata[63:32];
        item.box_center[2] = s_tdata[95:64];
        item.pos[0]        = s_tdata[127:96];
        item.pos[1]        = s_tdata[159:128];
        item.pos[2]        = s_tdata[191:160];
        item.half_size[0]  = s_tdata[222:192];
        item.half_size[1]  = s_tdata[253:223];
        item.half_size[2]  = s_tdata[284:254];
        item.axis[0]       = s_tdata[332:285];
        item.axis[1]       = s_tdata[380:333];
        item.axis[2]       = s_tdata[428:381];

        fcfg.center = center_reg;
        fcfg.half   = half_reg;
        fcfg.loose  = loose_reg;

        ctl.loose = loose_reg;
        ctl.depth = (depth_reg > LVL_W'(DEPTH_CAP)) ? LVL_W'(DEPTH_CAP) : depth_reg;
    end

    ocl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (fcfg),
        .in_valid  (s_tvalid),
        .item      (item),
        .out_valid (valid[0]),
        .dout      (data[0])
    );

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        ocl_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .ctl       (ctl),
            .in_valid  (valid[c]),
            .din       (data[c]),
            .out_valid (valid[c+1]),
            .dout      (data[c+1])
        );
    end

    assign m_tvalid = valid[NUM_CELLS];
    assign m_tdata  = {{(OUT_W-LVL_W-PATH_W-1){1'b0}}, data[NUM_CELLS].cause,
                       data[NUM_CELLS].path, data[NUM_CELLS].level};

endmodule

`default_nettype wire

[rtl/core/ocl_checker.sv]
// Port-level checker for the octree cell locator, bound to the top level.
`default_nettype none
`include "octree_cell_locator_macros.svh"

module ocl_checker
    import ocl_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    logic in_seen;
    assign in_seen = s_tvalid;

    // a held result keeps its value
    `OCL_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // the row only moves when the result slot is free
    `OCL_ASSERT(a_ready, aclk, aresetn, s_tready == (!m_tvalid || m_tready), "ready does not follow result stall")

    // level never goes past the deepest tree level
    `OCL_ASSERT_IMPLY(a_level, aclk, aresetn, m_tvalid, m_tdata[3:0] <= LVL_W'(DEPTH_CAP), "node level out of range")

    // octant bits at and above the reported level stay clear
    `OCL_ASSERT_IMPLY(a_path, aclk, aresetn, m_tvalid && (in_seen || !in_seen), (m_tdata[27:4] >> (6'(m_tdata[3:0]) * 6'd3)) == 24'd0, "path bits beyond level")

endmodule

bind octree_cell_locator ocl_checker u_ocl_checker (.*);

`default_nettype wire

[bench/tb_top.sv]
// Testbench for the octree cell locator: directed and random boxes against a built-in predictor.
`timescale 1ns / 100ps

module tb_top;
    import ocl_pkg::*;

    localparam int  LATENCY     = DEPTH_CAP + 4;
    localparam int  CYCLE_LIMIT = 300000;

    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    localparam logic MODE_STRICT   = 1'b0;
    localparam logic MODE_LOOSE    = 1'b1;
    localparam logic STOP_LEAF     = 1'b0;
    localparam logic STOP_STRADDLE = 1'b1;

    typedef struct packed {
        logic [2:0][31:0] box_center;
        logic [2:0][31:0] pos;
        logic [2:0][30:0] half_size;
        logic [2:0][47:0] axis;
    } box_req_t;

    typedef struct packed {
        logic [3:0]  level;
        logic [23:0] path;
        logic        cause;
    } node_pick_t;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_we    = 1'b0;
    logic [2:0]       cfg_index = '0;
    logic [31:0]      cfg_wdata = '0;

    // register mirror, at reset values
    logic [2:0][31:0] tree_center = '0;
    logic [30:0]      tree_half   = 31'd65536;
    logic             tree_loose  = MODE_STRICT;
    logic [3:0]       tree_depth  = 4'd4;

    node_pick_t pending_nodes[$];
    int         n_sent       = 0;
    int         n_checked    = 0;
    int         n_mismatch   = 0;
    int         n_cycles     = 0;
    int         tx_idle_pct  = 0;
    int         rx_idle_pct  = 0;
    int         rx_hold_left = 0;

    octree_cell_locator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Walks the tree from the root down to the stopping node for one box.
    function automatic node_pick_t locate_node(input box_req_t b);
        node_pick_t         res;
        longint             tgt[3];
        longint             node[3];
        longint             rad[3];
        longint             hw, d, mag, sum;
        logic signed [31:0] s32;
        logic signed [15:0] comp;
        logic [2:0]         oct;
        logic               stop, done;
        int                 depth;
        res   = '0;
        hw    = longint'({33'd0, tree_half}) <<< (FB - 16);
        depth = (tree_depth > DEPTH_CAP) ? DEPTH_CAP : tree_depth;
        for (int a = 0; a < 3; a++) begin
            sum = 0;
            for (int k = 0; k < 3; k++) begin
                comp = b.axis[k][16*a +: 16];
                mag  = comp;
                if (mag < 0) mag = -mag;
                sum += mag * longint'({33'd0, b.half_size[k]});
            end
            rad[a]  = sum >>> RSH;
            s32     = (tree_loose == MODE_LOOSE) ? b.pos[a] : b.box_center[a];
            tgt[a]  = s32;
            tgt[a]  = tgt[a] <<< (FB - 16);
            s32     = tree_center[a];
            node[a] = s32;
            node[a] = node[a] <<< (FB - 16);
        end
        done = 1'b0;
        for (int lv = 0; lv <= DEPTH_CAP && !done; lv++) begin
            oct  = '0;
            stop = 1'b0;
            for (int a = 0; a < 3; a++) begin
                if (!stop) begin
                    d   = tgt[a] - node[a];
                    mag = (d < 0) ? -d : d;
                    if ((tree_loose == MODE_LOOSE) ? (mag > 2 * hw - rad[a]) : (mag < rad[a]))
                        stop = 1'b1;
                    else if (d > 0)
                        oct[a] = 1'b1;
                end
            end
            res.level = 4'(lv);
            if (stop) begin
                res.cause = STOP_STRADDLE;
                done = 1'b1;
            end else if (lv >= depth) begin
                res.cause = STOP_LEAF;
                done = 1'b1;
            end else begin
                res.path[3*lv +: 3] = oct;
                hw = hw >>> 1;
                for (int a = 0; a < 3; a++)
                    node[a] += oct[a] ? hw : -hw;
            end
        end
        return res;
    endfunction

    function automatic logic [IN_W-1:0] pack_box(input box_req_t b);
        logic [IN_W-1:0] v;
        v = '0;
        for (int a = 0; a < 3; a++) begin
            v[32*a +: 32]       = b.box_center[a];
            v[96 + 32*a +: 32]  = b.pos[a];
            v[192 + 31*a +: 31] = b.half_size[a];
            v[285 + 48*a +: 48] = b.axis[a];
        end
        return v;
    endfunction

    // Same point for centre and position; axis k carries diag in its k-th component.
    function automatic box_req_t mk_box(input logic [31:0] cx, input logic [31:0] cy,
                                        input logic [31:0] cz, input logic [30:0] hs,
                                        input logic [15:0] diag);
        box_req_t b;
        b.box_center = {cz, cy, cx};
        b.pos        = {cz, cy, cx};
        for (int k = 0; k < 3; k++) begin
            b.half_size[k] = hs;
            b.axis[k]      = 48'(diag) << (16 * k);
        end
        return b;
    endfunction

    // Point around a root centre coordinate; grid offsets are multiples of tree_half >> n.
    function automatic logic [31:0] near_point(input logic [31:0] c, input bit grid);
        logic [31:0] off;
        if (grid)
            off = (32'(tree_half) >> $urandom_range(8)) * $urandom_range(3);
        else
            off = $urandom_range(tree_half) << $urandom_range(1);
        if ($urandom_range(1)) off = -off;
        return c + off;
    endfunction

    function automatic box_req_t random_box();
        box_req_t    b;
        int          style;
        logic [15:0] comp;
        style = $urandom_range(99);
        for (int a = 0; a < 3; a++) begin
            if (style < 6) begin
                b.box_center[a] = $urandom;
                b.pos[a]        = $urandom;
                b.half_size[a]  = 31'($urandom);
                b.axis[a]       = {16'($urandom), 32'($urandom)};
            end else begin
                b.box_center[a] = near_point(tree_center[a], style < 20);
                b.pos[a]        = near_point(tree_center[a], style < 20);
                if (style < 20)
                    b.half_size[a] = 31'($urandom_range(3));
                else
                    b.half_size[a] = 31'($urandom_range(tree_half >> $urandom_range(24, 2)));
                for (int k = 0; k < 3; k++) begin
                    comp = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(16384));
                    if ($urandom_range(1)) comp = -comp;
                    b.axis[a][16*k +: 16] = comp;
                end
            end
        end
        return b;
    endfunction

    function automatic logic [31:0] rand_center();
        return $urandom_range(32'h7FFF_FFFF) - 32'h4000_0000;
    endfunction

    task automatic offer_box(input box_req_t b);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_box(b);
        do @(posedge aclk); while (!s_tready);
        pending_nodes = {pending_nodes, locate_node(b)};
        n_sent++;
    endtask

    task automatic wait_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_nodes.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ROOT_CX:   tree_center[0] = val;
            REG_ROOT_CY:   tree_center[1] = val;
            REG_ROOT_CZ:   tree_center[2] = val;
            REG_ROOT_HALF: tree_half      = val[30:0];
            REG_LOOSE:     tree_loose     = val[0];
            REG_DEPTH:     tree_depth     = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_tree(input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
                            input logic [31:0] half, input logic loose, input logic [3:0] depth);
        write_reg(REG_ROOT_CX, cx);
        write_reg(REG_ROOT_CY, cy);
        write_reg(REG_ROOT_CZ, cz);
        write_reg(REG_ROOT_HALF, half);
        write_reg(REG_LOOSE, 32'(loose));
        write_reg(REG_DEPTH, 32'(depth));
    endtask

    // reset tree: unit root at the origin, strict, depth 4
    task automatic test_strict_directed();
        offer_box(mk_box(0, 0, 0, 0, 0));
        offer_box(mk_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
        offer_box(mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0));
        offer_box(mk_box(0, 0, 0, 31'h7FFF_FFFF, 16'h8000));
        // offset equal to radius does not straddle at the root
        offer_box(mk_box(32768, 32768, 32768, 32768, 16'h4000));
        offer_box(mk_box(32767, 32768, 32768, 32768, 16'h4000));
        offer_box(mk_box(32768, 32'hFFFF_8000, 32768, 32768, 16'hC000));
        wait_results();
    endtask

    task automatic test_loose_directed();
        write_reg(REG_LOOSE, 32'(MODE_LOOSE));
        // bound is 2*hw - r = 1.5 at the root
        offer_box(mk_box(98304, 98304, 98304, 32768, 16'h4000));
        offer_box(mk_box(98305, 98304, 98304, 32768, 16'h4000));
        offer_box(mk_box(32'hFFFE_8000, 32'hFFFE_8000, 32'hFFFE_8000, 32768, 16'h4000));
        // radius above twice the half width
        offer_box(mk_box(0, 0, 0, 196608, 16'h4000));
        offer_box(mk_box(0, 0, 0, 0, 0));
        wait_results();
    endtask

    task automatic test_depth_limits();
        write_reg(REG_DEPTH, 0);
        offer_box(mk_box(0, 0, 0, 0, 0));
        offer_box(mk_box(0, 0, 0, 31'h7FFF_FFFF, 16'h8000));
        wait_results();
        write_reg(REG_DEPTH, 9);
        offer_box(mk_box(0, 0, 0, 0, 0));
        offer_box(mk_box(1, 32'hFFFF_FFFF, 1, 0, 0));
        wait_results();
        write_reg(REG_LOOSE, 32'(MODE_STRICT));
        write_reg(REG_DEPTH, 15);
        offer_box(mk_box(0, 0, 0, 0, 0));
        wait_results();
        // a leaf that the box straddles still reports a straddle
        write_reg(REG_DEPTH, 1);
        offer_box(mk_box(32768, 32768, 32768, 32768, 16'h4000));
        offer_box(mk_box(32768, 32768, 32768, 0, 0));
        wait_results();
    endtask

    task automatic test_register_masking();
        write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_7, 32'hFFFF_FFFF);
        write_reg(REG_ROOT_HALF, 32'hFFFF_FFFF);
        write_reg(REG_LOOSE, 32'd2);
        write_reg(REG_DEPTH, 32'h1F);
        write_reg(REG_ROOT_CX, 32'h7FFF_FFFF);
        write_reg(REG_ROOT_CY, 32'h8000_0000);
        write_reg(REG_ROOT_CZ, 32'h0012_3456);
        offer_box(mk_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h0012_3456, 0, 0));
        offer_box(mk_box(0, 0, 0, 31'h0001_0000, 16'h7FFF));
        repeat (2) offer_box(random_box());
        wait_results();
    endtask

    task automatic test_random_trees();
        for (int ph = 0; ph < 9; ph++) begin
            tx_idle_pct = (ph < 3) ? 11 : (ph < 6) ? 51 : 0;
            rx_idle_pct = (ph < 3) ? 51 : (ph < 6) ? 11 : 0;
            case (ph)
                0: set_tree(0, 0, 0, 65536, MODE_STRICT, 8);
                1: set_tree(rand_center(), rand_center(), rand_center(),
                            $urandom_range(1 << 24), MODE_LOOSE, 8);
                2: set_tree(rand_center(), rand_center(), rand_center(),
                            $urandom_range(1 << 28), MODE_STRICT, 3);
                3: set_tree(0, 0, 0, 1 << 20, MODE_LOOSE, 15);
                4: set_tree(rand_center(), rand_center(), rand_center(), 16, MODE_STRICT, 8);
                5: set_tree(rand_center(), rand_center(), rand_center(),
                            $urandom_range(1 << 22), MODE_LOOSE, 0);
                6: set_tree(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            MODE_STRICT, 8);
                7: set_tree(rand_center(), rand_center(), rand_center(), 0, MODE_LOOSE, 5);
                default: set_tree($urandom, $urandom, $urandom, $urandom,
                                  1'($urandom_range(1)), 4'($urandom_range(15)));
            endcase
            repeat (200) offer_box(random_box());
            wait_results();
        end
    endtask

    // receiver holds off while requests keep coming, so the row fills and stalls
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        set_tree(0, 0, 0, 65536, MODE_LOOSE, 8);
        rx_hold_left = 400;
        repeat (60) offer_box(random_box());
        wait_results();
    endtask

    task automatic test_sender_pause();
        tx_idle_pct = 0;
        rx_idle_pct = 11;
        repeat (12) begin
            offer_box(random_box());
            wait_results();
        end
    endtask

    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            m_tready     <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        node_pick_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_nodes.size() == 0) begin
                $error("unexpected result: %h", m_tdata);
                n_mismatch++;
            end else begin
                want = pending_nodes.pop_front();
                if (m_tdata[3:0] !== want.level) begin
                    $error("node_level: expected %0d, got %0d", want.level, m_tdata[3:0]);
                    n_mismatch++;
                end
                if (m_tdata[27:4] !== want.path) begin
                    $error("node_path: expected %h, got %h", want.path, m_tdata[27:4]);
                    n_mismatch++;
                end
                if (m_tdata[28] !== want.cause) begin
                    $error("stop_cause: expected %0d, got %0d", want.cause, m_tdata[28]);
                    n_mismatch++;
                end
                n_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", n_cycles,
                     pending_nodes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_strict_directed();
        test_loose_directed();
        test_depth_limits();
        test_register_masking();
        test_random_trees();
        test_backpressure();
        test_sender_pause();
        wait_results();
        repeat (3 * LATENCY) @(posedge aclk);
        $display("%0d requests, %0d results checked: strict and loose trees, depths 0 to 15,",
                 n_sent, n_checked);
        $display("root extremes, long receiver hold-off and sender pauses; %0d mismatches",
                 n_mismatch);
        if (n_mismatch == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
